// File: rtl/cst_pkg.sv
// ---------------------------------------------------------------------------
// cst_pkg - shared types and constants of the C source tokenizer
// Scan modes, token classes, character codes, the keyword list and the
// exact keyword compare.
// ---------------------------------------------------------------------------
package cst_pkg;

	// Scan mode between bytes
	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_DIRECTIVE,
		MODE_LINE,
		MODE_BLOCK,
		MODE_NUMBER,
		MODE_WORD
	} mode_t;

	// Token classes as they appear on the result port
	localparam logic [2:0] CLS_DIRECTIVE = 3'd0;
	localparam logic [2:0] CLS_COMMENT   = 3'd1;
	localparam logic [2:0] CLS_OPERATOR  = 3'd2;
	localparam logic [2:0] CLS_PUNCT     = 3'd3;
	localparam logic [2:0] CLS_NUMBER    = 3'd4;
	localparam logic [2:0] CLS_IDENT     = 3'd5;
	localparam logic [2:0] CLS_KEYWORD   = 3'd6;
	localparam logic [2:0] CLS_ERROR     = 3'd7;

	// Character codes
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_SLASH   = 8'h2F;

	localparam int KW_COUNT = 32;
	localparam int KW_CHARS = 8;

	// Keywords, right-justified and zero-padded: first char is the highest nonzero byte
	localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
		"auto", "break", "case", "char", "const", "continue", "default", "do",
		"double", "else", "enum", "extern", "float", "for", "goto", "if",
		"int", "long", "register", "return", "short", "signed", "sizeof", "static",
		"struct", "switch", "typedef", "union", "unsigned", "void", "volatile", "while"
	};

	// One result record
	typedef struct packed {
		logic [2:0]  cls;
		logic [15:0] len;
		logic [31:0] off;
		logic        last;
	} tok_rec_t;

	// Record plus a flag that says whether a token was closed
	typedef struct packed {
		logic     hit;
		tok_rec_t rec;
	} close_res_t;

	// Exact keyword match; chars holds char j at [8j+:8], len is 1..8
	function automatic logic kw_match(input logic [8*KW_CHARS-1:0] chars,
		input logic [3:0] len);
		logic any;
		logic hit;
		int   kl;
		any = 1'b0;
		for (int i = 0; i < KW_COUNT; i++) begin
			kl = 0;
			for (int k = 0; k < KW_CHARS; k++) begin
				if (KW_TEXT[i][8*k +: 8] != 8'd0)
					kl = kl + 1;
			end
			hit = (len == 4'(kl));
			for (int j = 0; j < KW_CHARS; j++) begin
				if (j < kl && KW_TEXT[i][8*((kl - 1 - j) & 7) +: 8] != chars[8*j +: 8])
					hit = 1'b0;
			end
			any = any | hit;
		end
		return any;
	endfunction

	// Character classes
	function automatic logic is_num_char(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_word_start(input logic [7:0] b);
		return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
			(b == CH_UNDER);
	endfunction

	function automatic logic is_ws_char(input logic [7:0] b);
		return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D) ||
			(b == 8'h0B) || (b == 8'h0C);
	endfunction

	function automatic logic is_op(input logic [7:0] b);
		logic r;
		case (b) inside
			8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25, 8'h21, 8'h7E, 8'h26, 8'h7C,
			8'h5E, 8'h3F, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h3C, 8'h3E, 8'h2E: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_punct(input logic [7:0] b);
		logic r;
		case (b) inside
			8'h3B, 8'h3A, 8'h2C, 8'h27, 8'h22, 8'h7B, 8'h7D: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/c_source_tokenizer_top.sv
// The records of a byte are registered into the result queue and offered from its head.
// Takes one byte per cycle while the five-entry result queue holds at most two
// records; a byte yields up to three records, drained one per cycle unless stalled.
// Reset clears scan mode, counters, held byte and queue count at once; the word
// character buffer is not reset and is written before it is read.
// ---------------------------------------------------------------------------
// c_source_tokenizer_top - byte-serial C source tokenizer
// Scans one byte per cycle unless stalled and queues token records (class, length, offset).
// ---------------------------------------------------------------------------
module c_source_tokenizer_top #(
	parameter int KEYWORD_MAX_CHARS = 8,
	parameter int LENGTH_BITS       = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  source_byte,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  token_class,
	output logic [15:0] token_length,
	output logic [31:0] token_offset,
	output logic        last_of_run
);
	import cst_pkg::*;

	localparam int WIDX   = $clog2(KEYWORD_MAX_CHARS);
	localparam int QDEPTH = 5;
	localparam int QCW    = $clog2(QDEPTH + 1);
	localparam int MAXRES = 3;
	localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);
	localparam logic [LENGTH_BITS-1:0] LEN_TWO = LENGTH_BITS'(2);
	localparam logic [LENGTH_BITS-1:0] LEN_KW  = LENGTH_BITS'(KW_CHARS);
	localparam logic [LENGTH_BITS-1:0] LEN_KMX = LENGTH_BITS'(KEYWORD_MAX_CHARS);

	// Scanner state
	mode_t                  mode_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [31:0]            start_q;
	logic [31:0]            pos_q;
	logic [7:0]             held_q;
	logic                   held_v_q;
	logic                   star_q;
	logic [7:0]             word_q [KEYWORD_MAX_CHARS];

	// Result queue, head at slot 0
	tok_rec_t               q_q [QDEPTH];
	logic [QCW-1:0]         cnt_q;

	// Next-state values
	mode_t                  m_c;
	logic [LENGTH_BITS-1:0] len_c;
	logic [31:0]            st_c;
	logic [31:0]            pos_c;
	logic [7:0]             hb_c;
	logic                   hv_c;
	logic                   star_c;
	logic [7:0]             wd_c [KEYWORD_MAX_CHARS];
	tok_rec_t               rec_c [MAXRES];
	logic [1:0]             n_c;
	logic                   cl_c;
	logic                   sr_c;
	close_res_t             cr_c;
	tok_rec_t               q_c [QDEPTH];
	logic [QCW-1:0]         cnt_c;

	logic                   in_take;
	logic                   out_take;

	function automatic logic [15:0] len16(input logic [LENGTH_BITS-1:0] l);
		logic [31:0] w;
		w = 32'(l);
		return w[15:0];
	endfunction

	function automatic logic [LENGTH_BITS-1:0] grow(input logic [LENGTH_BITS-1:0] l);
		return (l == '1) ? l : l + LEN_ONE;
	endfunction

	// Record for the token that closes now, if any
	function automatic close_res_t close_tok(input logic hv, input mode_t m,
		input logic [LENGTH_BITS-1:0] l, input logic [31:0] st,
		input logic [7:0] wd [KEYWORD_MAX_CHARS]);
		close_res_t r;
		logic [8*KW_CHARS-1:0] chars;
		for (int j = 0; j < KW_CHARS; j++)
			chars[8*j +: 8] = wd[j];
		r.hit      = 1'b1;
		r.rec.len  = len16(l);
		r.rec.off  = st;
		r.rec.last = 1'b0;
		r.rec.cls  = CLS_ERROR;
		if (hv) begin
			r.rec.cls = CLS_OPERATOR;
			r.rec.len = 16'd1;
		end else begin
			case (m)
				MODE_DIRECTIVE: r.rec.cls = CLS_DIRECTIVE;
				MODE_LINE, MODE_BLOCK: r.rec.cls = CLS_COMMENT;
				MODE_NUMBER: r.rec.cls = CLS_NUMBER;
				MODE_WORD: begin
					r.rec.cls = (l <= LEN_KW && kw_match(chars, l[3:0])) ?
						CLS_KEYWORD : CLS_IDENT;
				end
				default: r.hit = 1'b0;
			endcase
		end
		return r;
	endfunction

	assign in_stall = (cnt_q > QCW'(QDEPTH - MAXRES));
	assign in_take  = in_valid && !in_stall;
	assign out_valid = (cnt_q != '0);
	assign out_take  = out_valid && !out_stall;

	assign token_class  = q_q[0].cls;
	assign token_length = q_q[0].len;
	assign token_offset = q_q[0].off;
	assign last_of_run  = q_q[0].last;

	// Scan one byte: main step, optional close and restart, then end-of-input flush
	always_comb begin
		m_c    = mode_q;
		len_c  = len_q;
		st_c   = start_q;
		hb_c   = held_q;
		hv_c   = held_v_q;
		star_c = star_q;
		wd_c   = word_q;
		n_c    = 2'd0;
		cl_c   = 1'b0;
		sr_c   = 1'b0;
		cr_c   = '0;
		for (int k = 0; k < MAXRES; k++)
			rec_c[k] = '0;

		if (hv_c) begin
			if (hb_c == CH_SLASH && source_byte == CH_SLASH) begin
				hv_c  = 1'b0;
				m_c   = MODE_LINE;
				len_c = LEN_TWO;
			end else if (hb_c == CH_SLASH && source_byte == CH_STAR) begin
				hv_c   = 1'b0;
				m_c    = MODE_BLOCK;
				len_c  = LEN_TWO;
				star_c = 1'b0;
			end else if (hb_c == CH_STAR && source_byte == CH_SLASH) begin
				hv_c = 1'b0;
				rec_c[n_c] = '{cls: CLS_ERROR, len: 16'd2, off: st_c, last: 1'b0};
				n_c   = n_c + 2'd1;
				len_c = '0;
			end else begin
				cl_c = 1'b1;
				sr_c = 1'b1;
			end
		end else begin
			case (m_c)
				MODE_DIRECTIVE, MODE_LINE: begin
					len_c = grow(len_c);
					if (source_byte == CH_NEWLINE)
						cl_c = 1'b1;
				end
				MODE_BLOCK: begin
					len_c = grow(len_c);
					if (star_c && source_byte == CH_SLASH)
						cl_c = 1'b1;
					else
						star_c = (source_byte == CH_STAR);
				end
				MODE_NUMBER: begin
					if (is_num_char(source_byte) || source_byte == CH_DOT) begin
						len_c = grow(len_c);
					end else begin
						cl_c = 1'b1;
						sr_c = 1'b1;
					end
				end
				MODE_WORD: begin
					if (is_word_start(source_byte) || is_num_char(source_byte)) begin
						if (len_c < LEN_KMX)
							wd_c[len_c[WIDX-1:0]] = source_byte;
						len_c = grow(len_c);
					end else begin
						cl_c = 1'b1;
						sr_c = 1'b1;
					end
				end
				default: begin
					m_c  = MODE_IDLE;
					sr_c = 1'b1;
				end
			endcase
		end

		// Close the open token
		if (cl_c) begin
			cr_c = close_tok(hv_c, m_c, len_c, st_c, wd_c);
			if (cr_c.hit) begin
				rec_c[n_c] = cr_c.rec;
				n_c = n_c + 2'd1;
			end
			hv_c   = 1'b0;
			m_c    = MODE_IDLE;
			len_c  = '0;
			star_c = 1'b0;
		end

		// Start a token with this byte
		if (sr_c && !is_ws_char(source_byte)) begin
			if (source_byte == CH_HASH) begin
				m_c   = MODE_DIRECTIVE;
				st_c  = pos_q;
				len_c = LEN_ONE;
			end else if (source_byte == CH_SLASH || source_byte == CH_STAR) begin
				hv_c  = 1'b1;
				hb_c  = source_byte;
				st_c  = pos_q;
				len_c = LEN_ONE;
			end else if (is_op(source_byte)) begin
				rec_c[n_c] = '{cls: CLS_OPERATOR, len: 16'd1, off: pos_q, last: 1'b0};
				n_c = n_c + 2'd1;
			end else if (is_punct(source_byte)) begin
				rec_c[n_c] = '{cls: CLS_PUNCT, len: 16'd1, off: pos_q, last: 1'b0};
				n_c = n_c + 2'd1;
			end else if (is_num_char(source_byte)) begin
				m_c   = MODE_NUMBER;
				st_c  = pos_q;
				len_c = LEN_ONE;
			end else if (is_word_start(source_byte)) begin
				m_c      = MODE_WORD;
				st_c     = pos_q;
				len_c    = LEN_ONE;
				wd_c[0]  = source_byte;
			end else begin
				rec_c[n_c] = '{cls: CLS_ERROR, len: 16'd1, off: pos_q, last: 1'b0};
				n_c = n_c + 2'd1;
			end
		end

		// Flush at end of input
		if (end_of_input) begin
			cr_c = close_tok(hv_c, m_c, len_c, st_c, wd_c);
			if (cr_c.hit && n_c < 2'd3) begin
				rec_c[n_c] = cr_c.rec;
				n_c = n_c + 2'd1;
			end
			hv_c   = 1'b0;
			m_c    = MODE_IDLE;
			len_c  = '0;
			star_c = 1'b0;
			pos_c  = '0;
		end else begin
			pos_c = pos_q + 32'd1;
		end

		// Mark the final record of this byte
		if (n_c != 2'd0)
			rec_c[n_c - 2'd1].last = 1'b1;
	end

	// Pop the head, then append this byte's records
	always_comb begin
		q_c   = q_q;
		cnt_c = cnt_q;
		if (out_take) begin
			for (int i = 0; i < QDEPTH - 1; i++)
				q_c[i] = q_q[i + 1];
			cnt_c = cnt_c - QCW'(1);
		end
		if (in_take) begin
			for (int i = 0; i < QDEPTH; i++) begin
				for (int k = 0; k < MAXRES; k++) begin
					if (QCW'(k) < QCW'(n_c) && QCW'(i) == cnt_c + QCW'(k))
						q_c[i] = rec_c[k];
				end
			end
			cnt_c = cnt_c + QCW'(n_c);
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			len_q    <= '0;
			start_q  <= '0;
			pos_q    <= '0;
			held_q   <= '0;
			held_v_q <= 1'b0;
			star_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			cnt_q <= cnt_c;
			if (in_take) begin
				mode_q   <= m_c;
				len_q    <= len_c;
				start_q  <= st_c;
				pos_q    <= pos_c;
				held_q   <= hb_c;
				held_v_q <= hv_c;
				star_q   <= star_c;
			end
		end
	end

	// Payload: word buffer and queue slots
	always_ff @(posedge clk) begin
		if (in_take)
			word_q <= wd_c;
		q_q <= q_c;
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCW'(QDEPTH))
		else $error("result queue count beyond depth");

	a_held_code: assert property (@(posedge clk) disable iff (!arst_n)
		held_v_q |-> (held_q == CH_SLASH || held_q == CH_STAR))
		else $error("held byte is neither slash nor star");

	a_eoi_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && end_of_input) |=> (mode_q == MODE_IDLE && !held_v_q && pos_q == '0))
		else $error("scanner not idle after end of input");

	a_queue_grow: assert property (@(posedge clk) disable iff (!arst_n)
		!in_take |=> (cnt_q <= $past(cnt_q)))
		else $error("result queue grew without an input transfer");
`endif

endmodule

// File: sim/token_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// token_checker - predicts and checks the token records of the tokenizer
// Watches both channels. Each byte transfer runs through a private scanner
// that builds the expected records. Each result transfer is compared field by
// field with the oldest of them. The mismatch count and the number of
// records still owed go back to the testbench top.
// ---------------------------------------------------------------------------
module token_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  source_byte,
	input  logic        end_of_input,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  token_class,
	input  logic [15:0] token_length,
	input  logic [31:0] token_offset,
	input  logic        last_of_run,
	output int          errors,
	output int          tokens_due
);
	import cst_pkg::*;

	localparam int          WORD_KEEP = 8;
	localparam logic [15:0] LEN_TOP   = 16'hFFFF;

	string keyword_list [32] = '{
		"auto", "break", "case", "char", "const", "continue", "default", "do",
		"double", "else", "enum", "extern", "float", "for", "goto", "if",
		"int", "long", "register", "return", "short", "signed", "sizeof", "static",
		"struct", "switch", "typedef", "union", "unsigned", "void", "volatile", "while"
	};

	// Scanner state
	mode_t       scan_mode  = MODE_IDLE;
	logic [15:0] open_len   = '0;
	logic [31:0] open_start = '0;
	logic [31:0] byte_pos   = '0;
	logic [7:0]  held_byte  = '0;
	bit          held_valid = 1'b0;
	bit          star_seen  = 1'b0;
	logic [7:0]  word_buf [WORD_KEEP];

	// Records of the current byte, then the queue of records owed
	tok_rec_t step_recs [3];
	int       step_count;
	tok_rec_t due_tokens [$];

	initial begin
		errors     = 0;
		tokens_due = 0;
	end

	task automatic flag_mismatch(input string msg);
		$display("%0t ns: token mismatch: %s", $time, msg);
		errors++;
	endtask

	function automatic logic [15:0] bump(input logic [15:0] n);
		return (n == LEN_TOP) ? n : n + 16'd1;
	endfunction

	function automatic bit ch_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit ch_alpha(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
	endfunction

	function automatic bit ch_blank(input logic [7:0] b);
		case (b)
			8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit ch_operator(input logic [7:0] b);
		case (b)
			"+", "-", "*", "/", "%", "!", "~", "&", "|", "^", "?", "(", ")", "[", "]",
			"<", ">", ".": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit ch_punct(input logic [7:0] b);
		case (b)
			";", ":", ",", 8'h27, 8'h22, "{", "}": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Exact match of the open word against the keyword list
	function automatic bit word_is_reserved();
		bit same;
		if (open_len > WORD_KEEP)
			return 1'b0;
		foreach (keyword_list[i]) begin
			if (keyword_list[i].len() == open_len) begin
				same = 1'b1;
				for (int j = 0; j < keyword_list[i].len(); j++)
					if (8'(keyword_list[i][j]) != word_buf[j])
						same = 1'b0;
				if (same)
					return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic add_token(input logic [2:0] cls, input logic [15:0] len,
		input logic [31:0] off);
		if (step_count < 3) begin
			step_recs[step_count] = '{cls: cls, len: len, off: off, last: 1'b0};
			step_count++;
		end
	endtask

	// Emit whatever is open and drop back to idle
	task automatic close_token();
		logic [2:0] cls;
		if (held_valid) begin
			add_token(CLS_OPERATOR, 16'd1, open_start);
			held_valid = 1'b0;
		end else if (scan_mode != MODE_IDLE) begin
			case (scan_mode)
				MODE_DIRECTIVE: cls = CLS_DIRECTIVE;
				MODE_LINE, MODE_BLOCK: cls = CLS_COMMENT;
				MODE_NUMBER: cls = CLS_NUMBER;
				default: cls = word_is_reserved() ? CLS_KEYWORD : CLS_IDENT;
			endcase
			add_token(cls, open_len, open_start);
		end
		scan_mode = MODE_IDLE;
		open_len  = '0;
		star_seen = 1'b0;
	endtask

	// Begin a token on a byte seen while idle
	task automatic start_token(input logic [7:0] b, input logic [31:0] pos);
		if (!ch_blank(b)) begin
			if (b == CH_HASH) begin
				scan_mode  = MODE_DIRECTIVE;
				open_start = pos;
				open_len   = 16'd1;
			end else if (b == CH_SLASH || b == CH_STAR) begin
				held_valid = 1'b1;
				held_byte  = b;
				open_start = pos;
				open_len   = 16'd1;
			end else if (ch_operator(b)) begin
				add_token(CLS_OPERATOR, 16'd1, pos);
			end else if (ch_punct(b)) begin
				add_token(CLS_PUNCT, 16'd1, pos);
			end else if (ch_digit(b)) begin
				scan_mode  = MODE_NUMBER;
				open_start = pos;
				open_len   = 16'd1;
			end else if (ch_alpha(b)) begin
				scan_mode   = MODE_WORD;
				open_start  = pos;
				open_len    = 16'd1;
				word_buf[0] = b;
			end else begin
				add_token(CLS_ERROR, 16'd1, pos);
			end
		end
	endtask

	// Advance the scanner by one byte and queue the records it closes
	task automatic scan_byte(input logic [7:0] b, input logic eoi);
		logic [31:0] pos;
		pos        = byte_pos;
		step_count = 0;
		if (held_valid) begin
			if (held_byte == CH_SLASH && b == CH_SLASH) begin
				held_valid = 1'b0;
				scan_mode  = MODE_LINE;
				open_len   = 16'd2;
			end else if (held_byte == CH_SLASH && b == CH_STAR) begin
				held_valid = 1'b0;
				scan_mode  = MODE_BLOCK;
				open_len   = 16'd2;
				star_seen  = 1'b0;
			end else if (held_byte == CH_STAR && b == CH_SLASH) begin
				held_valid = 1'b0;
				add_token(CLS_ERROR, 16'd2, open_start);
				open_len = '0;
			end else begin
				close_token();
				start_token(b, pos);
			end
		end else begin
			case (scan_mode)
				MODE_DIRECTIVE, MODE_LINE: begin
					open_len = bump(open_len);
					if (b == CH_NEWLINE)
						close_token();
				end
				MODE_BLOCK: begin
					open_len = bump(open_len);
					if (star_seen && b == CH_SLASH)
						close_token();
					else
						star_seen = (b == CH_STAR);
				end
				MODE_NUMBER: begin
					if (ch_digit(b) || b == CH_DOT) begin
						open_len = bump(open_len);
					end else begin
						close_token();
						start_token(b, pos);
					end
				end
				MODE_WORD: begin
					if (ch_alpha(b) || ch_digit(b)) begin
						if (open_len < WORD_KEEP)
							word_buf[open_len[2:0]] = b;
						open_len = bump(open_len);
					end else begin
						close_token();
						start_token(b, pos);
					end
				end
				default: begin
					scan_mode = MODE_IDLE;
					start_token(b, pos);
				end
			endcase
		end

		// End of stream flushes and restarts the position count
		if (eoi) begin
			close_token();
			byte_pos = '0;
		end else begin
			byte_pos = pos + 32'd1;
		end

		if (step_count > 0)
			step_recs[step_count - 1].last = 1'b1;
		for (int i = 0; i < step_count; i++)
			due_tokens.push_back(step_recs[i]);
	endtask

	// Compare one result transfer with the oldest owed record
	task automatic check_token();
		tok_rec_t want;
		if (due_tokens.size() == 0) begin
			flag_mismatch($sformatf("unexpected record class %0d length %0d offset %0d",
				token_class, token_length, token_offset));
		end else begin
			want = due_tokens.pop_front();
			if (token_class !== want.cls)
				flag_mismatch($sformatf("class %0d, want %0d (offset %0d)",
					token_class, want.cls, want.off));
			if (token_length !== want.len)
				flag_mismatch($sformatf("length %0d, want %0d (offset %0d)",
					token_length, want.len, want.off));
			if (token_offset !== want.off)
				flag_mismatch($sformatf("offset %0d, want %0d", token_offset, want.off));
			if (last_of_run !== want.last)
				flag_mismatch($sformatf("last flag %0b, want %0b (offset %0d)",
					last_of_run, want.last, want.off));
		end
	endtask

	// Watch both channels on every rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_mode  = MODE_IDLE;
			open_len   = '0;
			open_start = '0;
			byte_pos   = '0;
			held_byte  = '0;
			held_valid = 1'b0;
			star_seen  = 1'b0;
			due_tokens.delete();
			tokens_due = 0;
		end else begin
			if (in_valid && !in_stall)
				scan_byte(source_byte, end_of_input);
			if (out_valid && !out_stall)
				check_token();
			tokens_due = due_tokens.size();
		end
	end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb - testbench top of the C source tokenizer
// Feeds byte streams (a directed set of corner cases, then random token
// sequences with random idling on both channels) and leaves prediction and
// checking to token_checker.
// ---------------------------------------------------------------------------
module tb;
	import cst_pkg::*;

	localparam int IDLE_LIMIT = 1000;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic [7:0]  source_byte  = 8'd0;
	logic        end_of_input = 1'b0;
	logic        out_stall    = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [2:0]  token_class;
	logic [15:0] token_length;
	logic [31:0] token_offset;
	logic        last_of_run;

	int   errors;
	int   tokens_due;
	bit   calm        = 1'b0;
	int   stall_left  = 0;
	int   dead_cycles = 0;
	logic in_taken    = 1'b0;

	// Bytes waiting to be fed, with their end-of-stream marks
	logic [7:0] text_q [$];
	logic       eoi_q [$];

	c_source_tokenizer_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.source_byte  (source_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_class  (token_class),
		.token_length (token_length),
		.token_offset (token_offset),
		.last_of_run  (last_of_run)
	);

	token_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.source_byte  (source_byte),
		.end_of_input (end_of_input),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_class  (token_class),
		.token_length (token_length),
		.token_offset (token_offset),
		.last_of_run  (last_of_run),
		.errors       (errors),
		.tokens_due   (tokens_due)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Note each byte transfer for the feeder
	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
	end

	// End the run when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			dead_cycles <= 0;
		end else if (dead_cycles == IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			dead_cycles <= dead_cycles + 1;
		end
	end

	// Stall the result side in random bursts
	always @(negedge clk) begin
		if (calm) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 11);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic add_byte(input logic [7:0] b);
		text_q.push_back(b);
		eoi_q.push_back(1'b0);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	task automatic mark_end();
		eoi_q[eoi_q.size() - 1] = 1'b1;
	endtask

	function automatic logic [7:0] pick(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	// Offer one byte, sometimes after a random gap, and hold it until transferred
	task automatic push_byte(input logic [7:0] b, input logic eoi);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid     <= 1'b1;
		source_byte  <= b;
		end_of_input <= eoi;
		do @(negedge clk); while (!in_taken);
	endtask

	task automatic send_text();
		while (text_q.size() > 0)
			push_byte(text_q.pop_front(), eoi_q.pop_front());
	endtask

	// Queue one keyword; trim drops its last char, extend appends a word char
	task automatic add_keyword(input bit trim, input bit extend);
		int         idx;
		int         n;
		int         kept;
		logic [7:0] c;
		idx  = $urandom_range(0, KW_COUNT - 1);
		n    = 0;
		kept = 0;
		for (int k = 0; k < KW_CHARS; k++)
			if (KW_TEXT[idx][8*k +: 8] != 8'd0)
				n++;
		for (int k = KW_CHARS - 1; k >= 0; k--) begin
			c = KW_TEXT[idx][8*k +: 8];
			if (c != 8'd0 && !(trim && kept == n - 1)) begin
				add_byte(c);
				kept++;
			end
		end
		if (extend)
			add_byte(pick("abcxyz_019"));
	endtask

	// Queue one random token, mostly well formed, then maybe a separator
	task automatic add_random_token();
		int n;
		case ($urandom_range(0, 12))
			0, 1: add_keyword(1'b0, 1'b0);
			2: add_keyword(1'($urandom_range(0, 1)), 1'b1);
			3: add_keyword(1'b1, 1'b0);
			4: begin
				n = $urandom_range(1, 12);
				add_byte(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
				repeat (n - 1)
					add_byte(pick("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789"));
			end
			5: begin
				add_byte(pick("0123456789"));
				repeat ($urandom_range(0, 5)) add_byte(pick("0123456789."));
			end
			6: add_byte(pick("+-%!~&|^?()[]<>."));
			7: add_byte(pick(";:,'\"{}"));
			8: begin
				add_byte(CH_HASH);
				repeat ($urandom_range(0, 6)) begin
					n = $urandom_range(0, 255);
					add_byte((n == CH_NEWLINE) ? 8'h41 : 8'(n));
				end
				add_byte(CH_NEWLINE);
			end
			9: begin
				add_text("//");
				repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(8'h20, 8'h7E)));
				add_byte(CH_NEWLINE);
			end
			10: begin
				add_text("/*");
				repeat ($urandom_range(0, 8)) add_byte(pick("**//a \n"));
				add_text("*/");
			end
			11: begin
				case ($urandom_range(0, 2))
					0: add_text("*/");
					1: add_byte(CH_SLASH);
					default: add_byte(CH_STAR);
				endcase
			end
			default: add_byte(8'($urandom_range(0, 255)));
		endcase
		case ($urandom_range(0, 5))
			0, 1: add_byte(8'h20);
			2: add_byte(pick("\t\n\r"));
			3: add_byte(8'($urandom_range(8'h0B, 8'h0C)));
			default: ;
		endcase
		if ($urandom_range(0, 11) == 0)
			mark_end();
	endtask

	initial begin
		int fed;
		int tokens;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: every class but identifier, held slash and star, comment corner cases
		add_text("#a\n");
		add_text("//\n");
		add_text("/*/*/");
		add_text("*/");
		add_text("/;");
		add_text("9.5 ");
		add_text("do(");
		add_byte(8'hFF);
		add_byte(8'h00);
		add_byte(CH_STAR);
		mark_end();
		send_text();

		// Random token sequences with idling, calm stretches now and then
		fed    = 0;
		tokens = 0;
		while (fed < 110) begin
			if (tokens % 8 == 0)
				calm = ($urandom_range(0, 3) == 0);
			add_random_token();
			fed += text_q.size();
			tokens++;
			send_text();
		end

		// Closing part without idling
		calm = 1'b1;
		fed  = 0;
		while (fed < 40) begin
			add_random_token();
			fed += text_q.size();
			if (fed >= 40)
				mark_end();
			send_text();
		end
		in_valid <= 1'b0;

		// Drain the owed records, then allow the result queue to settle
		while (tokens_due != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: c_source_tokenizer_top.f
rtl/cst_pkg.sv
rtl/c_source_tokenizer_top.sv
sim/token_checker.sv
sim/tb.sv
